// ===== src/sorted_list_insert_table_unit_macros.svh =====
// Assertion macros shared by the sorted list insert table unit
`ifndef SORTED_LIST_INSERT_TABLE_UNIT_MACROS_SVH
`define SORTED_LIST_INSERT_TABLE_UNIT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted
`define SLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define SLI_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/sli_pkg.sv =====
// Types and constants for the sorted list insert table unit
package sli_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EQ,
    ST_PLACE,
    ST_RD
  } sli_state_e;

endpackage

// ===== src/sorted_list_insert_table_unit.sv =====
// Sorted list insert table: bounded ascending table of signed words in one memory
//
//   channel   direction  handshake          payload
//   command   in         start_i / busy_o   kind_i, value_i, index_i
//   result    out        valid_o (strobe)   position_o, read_data_o, count_o, error_o
//
// An insert into an empty or full table, and a read past the count, give their result
// in the cycle after the transfer. A read within the count passes through the memory read
// and ST_RD, then the result register. A non-trivial insert walks the table downwards from
// the top entry, one memory read per cycle, shifting larger entries up and then following
// the run of equal entries, with one more step in ST_PLACE when the value lands at the
// bottom of the table.
// Reset clears the count, the state and the result valid flag; the memory is not cleared and needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "sorted_list_insert_table_unit_macros.svh"

module sorted_list_insert_table_unit #(
  parameter int unsigned DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                kind_i,
  input  logic signed [sli_pkg::VAL_W-1:0]    value_i,
  input  logic        [sli_pkg::IDX_W-1:0]    index_i,
  output logic                                valid_o,
  output logic        [sli_pkg::CNT_W-1:0]    position_o,
  output logic signed [sli_pkg::VAL_W-1:0]    read_data_o,
  output logic        [sli_pkg::CNT_W-1:0]    count_o,
  output logic                                error_o
);
  import sli_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // common width for comparing a read index against the count
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  // control state
  sli_state_e          state_q, state_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       count_q, count_d;
  logic signed [VAL_W-1:0] val_q, val_d;

  // result registers
  logic                res_valid_q, res_valid_d;
  logic [CNT_W-1:0]    res_pos_q, res_pos_d;
  logic [VAL_W-1:0]    res_data_q, res_data_d;
  logic                res_err_q, res_err_d;

  // memory ports
  logic [VAL_W-1:0]    mem_q [DEPTH];
  logic [VAL_W-1:0]    mem_rdata_q;
  logic [AW-1:0]       mem_ra;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [VAL_W-1:0]    mem_wd;

  logic                accept;
  logic [CW-1:0]       cnt_m1;
  logic                gt_v;
  logic                eq_v;
  logic                finish;
  logic [CW-1:0]       less_c;
  logic                idx_in_range;

  // terms for the checks at the end
  logic                full_ins;
  logic                drop_ok;
  logic                walking;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign cnt_m1 = count_q - 1'b1;
  assign idx_in_range = XW'(index_i) < XW'(count_q);

  // compare the entry just read against the value being inserted
  assign gt_v = $signed(mem_rdata_q) > val_q;
  assign eq_v = $signed(mem_rdata_q) == val_q;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    val_q      <= val_d;
    res_pos_q  <= res_pos_d;
    res_data_q <= res_data_d;
    res_err_q  <= res_err_d;
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    val_d       = val_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = val_q;
    mem_ra      = ptr_q;
    res_valid_d = 1'b0;
    res_pos_d   = '0;
    res_data_d  = '0;
    res_err_d   = 1'b0;
    finish      = 1'b0;
    less_c      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d = value_i;
          if (kind_i == KIND_INSERT) begin
            if (count_q == CW'(DEPTH)) begin
              // full table: drop the insert and flag it
              res_valid_d = 1'b1;
              res_err_d   = 1'b1;
            end else if (count_q == '0) begin
              mem_we      = 1'b1;
              mem_wa      = '0;
              mem_wd      = value_i;
              count_d     = count_q + 1'b1;
              res_valid_d = 1'b1;
            end else begin
              // start the walk at the top entry
              mem_ra  = cnt_m1[AW-1:0];
              ptr_d   = cnt_m1[AW-1:0];
              state_d = ST_SCAN;
            end
          end else begin
            if (idx_in_range) begin
              mem_ra  = AW'(index_i);
              state_d = ST_RD;
            end else begin
              res_valid_d = 1'b1;
              res_err_d   = 1'b1;
            end
          end
        end
      end

      ST_RD: begin
        res_valid_d = 1'b1;
        res_data_d  = mem_rdata_q;
        state_d     = ST_IDLE;
      end

      ST_SCAN: begin
        mem_we = 1'b1;
        mem_wa = ptr_q + 1'b1;
        if (gt_v) begin
          // shift the larger entry up by one
          mem_wd = mem_rdata_q;
          if (ptr_q == '0) begin
            state_d = ST_PLACE;
          end else begin
            mem_ra  = ptr_q - 1'b1;
            ptr_d   = ptr_q - 1'b1;
          end
        end else begin
          // place the value above the first entry not larger than it
          mem_wd = val_q;
          if (eq_v && ptr_q != '0) begin
            mem_ra  = ptr_q - 1'b1;
            ptr_d   = ptr_q - 1'b1;
            state_d = ST_EQ;
          end else if (eq_v) begin
            finish = 1'b1;
            less_c = '0;
          end else begin
            finish = 1'b1;
            less_c = CW'(ptr_q) + 1'b1;
          end
        end
      end

      ST_EQ: begin
        // follow the equal run down to its first entry
        if (eq_v && ptr_q != '0) begin
          mem_ra = ptr_q - 1'b1;
          ptr_d  = ptr_q - 1'b1;
        end else if (eq_v) begin
          finish = 1'b1;
          less_c = '0;
        end else begin
          finish = 1'b1;
          less_c = CW'(ptr_q) + 1'b1;
        end
      end

      ST_PLACE: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = val_q;
        finish = 1'b1;
        less_c = '0;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      res_valid_d = 1'b1;
      res_pos_d   = CNT_W'(less_c);
      count_d     = count_q + 1'b1;
      state_d     = ST_IDLE;
    end
  end

  assign valid_o     = res_valid_q;
  assign position_o  = res_pos_q;
  assign read_data_o = res_data_q;
  assign count_o     = CNT_W'(count_q);
  assign error_o     = res_err_q;

  assign full_ins = accept && (kind_i == KIND_INSERT) && (count_q == CW'(DEPTH));
  assign drop_ok  = valid_o && error_o;
  assign walking  = (state_q == ST_SCAN) || (state_q == ST_EQ);

  `SLI_NEVER(a_count_bound, clk_i, rst_ni, count_q > CW'(DEPTH), "count exceeds table depth")
  `SLI_ASSERT(a_full_drop, clk_i, rst_ni, full_ins |=> (drop_ok && $stable(count_q)), "no full drop")
  `SLI_ASSERT(a_walk_in_range, clk_i, rst_ni, walking |-> (CW'(ptr_q) < count_q), "walk past count")
  `SLI_ASSERT(a_result_cause, clk_i, rst_ni, valid_o |-> $past(busy_o || start_i), "stray result")

endmodule
